>>> rtl/sfe_pkg.sv
package sfe_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int PIX_COUNT     = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(PIX_COUNT);
    localparam int COL_W         = $clog2(SCREEN_WIDTH);
    localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
    localparam int PIXEL_W       = 16;

    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_RECT   = 3'd1;
    localparam logic [2:0] MODE_ROUND  = 3'd2;
    localparam logic [2:0] MODE_CIRCLE = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

endpackage

>>> rtl/shape_fill_engine.sv
// Shape fill engine over an RGB565 frame buffer held in one on-chip RAM.
// A command beat is taken at a rising edge where start is high and busy is
// low. The command is clear, fill rectangle, fill rounded rectangle, fill
// circle, or read one pixel; shapes are clipped to the screen.
// Every command gives exactly one result beat: done is high for one cycle and
// read_color carries the pixel for a read and zero for every other command.
// The receiver cannot stall, so the result beat is always taken in that cycle.
// busy stays high from the accepted command until the cycle of its result
// beat; a new command may be given in the cycle where done is high.
// A fill walks its clipped bounding box one pixel per cycle, bounded by the
// single write port of the frame RAM, and the corner or circle test runs in
// a three-stage pipeline in front of that port. All writes of a fill have
// landed before its result beat, so a following read sees them. Reset clears
// the control state only; the frame contents are undefined until written,
// and a clear command is expected first.
module shape_fill_engine
    import sfe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                mode,
    input  logic signed [10:0]        pos_x,
    input  logic signed [10:0]        pos_y,
    input  logic [9:0]                width,
    input  logic [9:0]                height,
    input  logic [8:0]                radius,
    input  logic [15:0]               fill_color,
    output logic                      done,
    output logic [15:0]               read_color
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN,
        ST_RD_WAIT
    } state_t;

    localparam logic signed [12:0] XMAX = 13'(SCREEN_WIDTH - 1);
    localparam logic signed [12:0] YMAX = 13'(SCREEN_HEIGHT - 1);

    function automatic logic signed [12:0] smax(input logic signed [12:0] a,
                                                input logic signed [12:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [12:0] smin(input logic signed [12:0] a,
                                                input logic signed [12:0] b);
        return (a < b) ? a : b;
    endfunction

    state_t                   state_reg;
    logic                     done_reg;
    logic [PIXEL_W-1:0]       result_reg;

    logic [2:0]               mode_reg;
    logic signed [10:0]       ox_reg;
    logic signed [10:0]       oy_reg;
    logic [9:0]               w_reg;
    logic [9:0]               h_reg;
    logic [8:0]               r_reg;
    logic [PIXEL_W-1:0]       color_reg;
    logic signed [11:0]       xlo_reg;
    logic signed [11:0]       xhi_reg;
    logic signed [11:0]       ylo_reg;
    logic signed [11:0]       yhi_reg;
    logic                     empty_reg;

    logic signed [11:0]       dx_reg;
    logic signed [11:0]       dy_reg;
    logic [COL_W-1:0]         px_reg;
    logic [COL_W-1:0]         px_lo_reg;
    logic [ADDR_W-1:0]        row_base_reg;
    logic [17:0]              rr_reg;

    logic                     s1_v_reg;
    logic [ADDR_W-1:0]        s1_addr_reg;
    logic                     s1_test_reg;
    logic [9:0]               s1_ea_reg;
    logic [9:0]               s1_eb_reg;
    logic                     s2_v_reg;
    logic [ADDR_W-1:0]        s2_addr_reg;
    logic                     s2_test_reg;
    logic [19:0]              s2_sqa_reg;
    logic [19:0]              s2_sqb_reg;
    logic                     s3_v_reg;
    logic [ADDR_W-1:0]        s3_addr_reg;

    logic signed [12:0]       in_x;
    logic signed [12:0]       in_y;
    logic signed [12:0]       in_w;
    logic signed [12:0]       in_h;
    logic signed [12:0]       in_r;
    logic signed [12:0]       lo_x;
    logic signed [12:0]       hi_x;
    logic signed [12:0]       lo_y;
    logic signed [12:0]       hi_y;

    logic signed [12:0]       px_start;
    logic signed [12:0]       py_start;
    logic [ROW_W-1:0]         mul_row;
    logic [ADDR_W-1:0]        base_addr;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     rd_in_range;
    logic                     ram_re;
    logic [PIXEL_W-1:0]       ram_rdata;

    logic signed [12:0]       d_x;
    logic signed [12:0]       d_y;
    logic signed [12:0]       cr;
    logic signed [12:0]       cw;
    logic signed [12:0]       ch;
    logic                     c_left;
    logic                     c_right;
    logic                     c_top;
    logic                     c_bot;
    logic signed [12:0]       e_a;
    logic signed [12:0]       e_b;
    logic                     test_next;
    logic [20:0]              dist_sum;
    logic                     last_x;
    logic                     last_y;

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign read_color = result_reg;

    // Clip bounds of the command, as inclusive offsets from its origin.
    always_comb
    begin
        in_x = 13'(pos_x);
        in_y = 13'(pos_y);
        in_w = $signed({3'b000, width});
        in_h = $signed({3'b000, height});
        in_r = $signed({4'b0000, radius});
        if (mode == MODE_CIRCLE)
        begin
            lo_x = smax(-in_r, -in_x);
            hi_x = smin(in_r, XMAX - in_x);
            lo_y = smax(-in_r, -in_y);
            hi_y = smin(in_r, YMAX - in_y);
        end
        else if (mode == MODE_CLEAR)
        begin
            lo_x = '0;
            hi_x = XMAX;
            lo_y = '0;
            hi_y = YMAX;
        end
        else
        begin
            lo_x = smax(-in_x, 13'sd0);
            hi_x = smin(XMAX - in_x, in_w - 13'sd1);
            lo_y = smax(-in_y, 13'sd0);
            hi_y = smin(YMAX - in_y, in_h - 13'sd1);
        end
    end

    always_comb
    begin
        px_start    = 13'(ox_reg) + 13'(xlo_reg);
        py_start    = 13'(oy_reg) + 13'(ylo_reg);
        mul_row     = (mode_reg == MODE_READ) ? ROW_W'(oy_reg) : ROW_W'(py_start);
        base_addr   = ADDR_W'(mul_row) * ADDR_W'(SCREEN_WIDTH);
        rd_addr     = base_addr + ADDR_W'(ox_reg[COL_W-1:0]);
        rd_in_range = (ox_reg >= 0) && (13'(ox_reg) <= XMAX)
                      && (oy_reg >= 0) && (13'(oy_reg) <= YMAX);
        ram_re      = (state_reg == ST_SETUP) && (mode_reg == MODE_READ) && rd_in_range;
        last_x      = (dx_reg == xhi_reg);
        last_y      = (dy_reg == yhi_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP:
                begin
                    if (mode_reg == MODE_READ)
                    begin
                        if (rd_in_range)
                        begin
                            state_reg <= ST_RD_WAIT;
                        end
                        else
                        begin
                            state_reg  <= ST_IDLE;
                            done_reg   <= 1'b1;
                            result_reg <= '0;
                        end
                    end
                    else if (mode_reg inside {MODE_CLEAR, MODE_RECT, MODE_ROUND, MODE_CIRCLE}
                             && !empty_reg)
                    begin
                        state_reg <= ST_RUN;
                    end
                    else
                    begin
                        state_reg  <= ST_IDLE;
                        done_reg   <= 1'b1;
                        result_reg <= '0;
                    end
                end
                ST_RUN:
                begin
                    if (last_x && last_y)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!s1_v_reg && !s2_v_reg && !s3_v_reg)
                    begin
                        state_reg  <= ST_IDLE;
                        done_reg   <= 1'b1;
                        result_reg <= '0;
                    end
                end
                ST_RD_WAIT:
                begin
                    state_reg  <= ST_IDLE;
                    done_reg   <= 1'b1;
                    result_reg <= ram_rdata;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Command registers and the pixel walker.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            mode_reg  <= mode;
            ox_reg    <= (mode == MODE_CLEAR) ? 11'sd0 : pos_x;
            oy_reg    <= (mode == MODE_CLEAR) ? 11'sd0 : pos_y;
            w_reg     <= width;
            h_reg     <= height;
            r_reg     <= radius;
            color_reg <= (mode == MODE_CLEAR) ? '0 : fill_color;
            xlo_reg   <= 12'(lo_x);
            xhi_reg   <= 12'(hi_x);
            ylo_reg   <= 12'(lo_y);
            yhi_reg   <= 12'(hi_y);
            empty_reg <= (lo_x > hi_x) || (lo_y > hi_y);
        end
        if (state_reg == ST_SETUP)
        begin
            dx_reg       <= xlo_reg;
            dy_reg       <= ylo_reg;
            px_reg       <= COL_W'(px_start);
            px_lo_reg    <= COL_W'(px_start);
            row_base_reg <= base_addr;
            rr_reg       <= 18'(r_reg) * 18'(r_reg);
        end
        else if (state_reg == ST_RUN)
        begin
            if (last_x)
            begin
                dx_reg       <= xlo_reg;
                px_reg       <= px_lo_reg;
                dy_reg       <= dy_reg + 12'sd1;
                row_base_reg <= row_base_reg + ADDR_W'(SCREEN_WIDTH);
            end
            else
            begin
                dx_reg <= dx_reg + 12'sd1;
                px_reg <= px_reg + COL_W'(1);
            end
        end
    end

    // Corner and circle offsets. A rounded corner applies where the pixel
    // lies in both a corner column band and a corner row band; left wins
    // over right and top over bottom, which matches the corner order.
    always_comb
    begin
        d_x     = 13'(dx_reg);
        d_y     = 13'(dy_reg);
        cr      = $signed({4'b0000, r_reg});
        cw      = $signed({3'b000, w_reg});
        ch      = $signed({3'b000, h_reg});
        c_left  = d_x < cr;
        c_right = d_x >= cw - cr;
        c_top   = d_y < cr;
        c_bot   = d_y >= ch - cr;
        if (mode_reg == MODE_CIRCLE)
        begin
            e_a       = d_x;
            e_b       = d_y;
            test_next = 1'b1;
        end
        else if (mode_reg == MODE_ROUND)
        begin
            e_a       = c_left ? (cr - d_x) : (d_x - (cw - cr - 13'sd1));
            e_b       = c_top ? (cr - d_y) : (d_y - (ch - cr - 13'sd1));
            test_next = (c_left || c_right) && (c_top || c_bot);
        end
        else
        begin
            e_a       = '0;
            e_b       = '0;
            test_next = 1'b0;
        end
        dist_sum = 21'(s2_sqa_reg) + 21'(s2_sqb_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= (state_reg == ST_RUN);
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg && (!s2_test_reg || dist_sum <= 21'(rr_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= row_base_reg + ADDR_W'(px_reg);
        s1_test_reg <= test_next;
        s1_ea_reg   <= (e_a < 0) ? 10'(-e_a) : 10'(e_a);
        s1_eb_reg   <= (e_b < 0) ? 10'(-e_b) : 10'(e_b);
        s2_addr_reg <= s1_addr_reg;
        s2_test_reg <= s1_test_reg;
        s2_sqa_reg  <= 20'(s1_ea_reg) * 20'(s1_ea_reg);
        s2_sqb_reg  <= 20'(s1_eb_reg) * 20'(s1_eb_reg);
        s3_addr_reg <= s2_addr_reg;
    end

    sfe_ram #(
        .WIDTH(PIXEL_W),
        .DEPTH(PIX_COUNT)
    ) u_frame_ram (
        .clk  (clk),
        .we   (s3_v_reg),
        .waddr(s3_addr_reg),
        .wdata(color_reg),
        .re   (ram_re),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

endmodule

>>> rtl/sfe_ram.sv
module sfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> tb/testbench.sv
module testbench;

    import sfe_pkg::*;

    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
    localparam int WATCHDOG_LIMIT = 400000;

    class frame_model;
        logic [15:0] pixels [PIX_COUNT];
        logic [15:0] expected_colors [$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function void plot(int px, int py, logic [15:0] c);
            if (px >= 0 && px < SCREEN_WIDTH && py >= 0 && py < SCREEN_HEIGHT)
            begin
                pixels[py * SCREEN_WIDTH + px] = c;
            end
        endfunction

        function void paint_box(int xi, int yi, int wi, int hi, int ri, bit rounded,
                                logic [15:0] c);
            int dx0, dx1, dy0, dy1, ex, ey;
            bit in_corner;
            dy0 = (yi < 0) ? -yi : 0;
            dx0 = (xi < 0) ? -xi : 0;
            dy1 = (SCREEN_HEIGHT - yi > hi) ? hi : SCREEN_HEIGHT - yi;
            dx1 = (SCREEN_WIDTH - xi > wi) ? wi : SCREEN_WIDTH - xi;
            for (int dy = dy0; dy < dy1; dy++)
            begin
                for (int dx = dx0; dx < dx1; dx++)
                begin
                    in_corner = 1'b1;
                    if (dx < ri && dy < ri)
                    begin
                        ex = ri - dx;
                        ey = ri - dy;
                    end
                    else if (dx >= wi - ri && dy < ri)
                    begin
                        ex = dx - (wi - ri - 1);
                        ey = ri - dy;
                    end
                    else if (dx < ri && dy >= hi - ri)
                    begin
                        ex = ri - dx;
                        ey = dy - (hi - ri - 1);
                    end
                    else if (dx >= wi - ri && dy >= hi - ri)
                    begin
                        ex = dx - (wi - ri - 1);
                        ey = dy - (hi - ri - 1);
                    end
                    else
                    begin
                        in_corner = 1'b0;
                    end
                    if (!rounded || !in_corner || ex * ex + ey * ey <= ri * ri)
                    begin
                        plot(xi + dx, yi + dy, c);
                    end
                end
            end
        endfunction

        function void note_command(logic [2:0] m, logic signed [10:0] x,
                                   logic signed [10:0] y, logic [9:0] w, logic [9:0] h,
                                   logic [8:0] r, logic [15:0] c);
            int xi, yi, wi, hi, ri;
            logic [15:0] value;
            xi = x;
            yi = y;
            wi = w;
            hi = h;
            ri = r;
            value = '0;
            case (m)
                MODE_CLEAR:
                begin
                    foreach (pixels[i])
                    begin
                        pixels[i] = '0;
                    end
                end
                MODE_RECT:   paint_box(xi, yi, wi, hi, ri, 1'b0, c);
                MODE_ROUND:  paint_box(xi, yi, wi, hi, ri, 1'b1, c);
                MODE_CIRCLE:
                begin
                    for (int dy = -ri; dy <= ri; dy++)
                    begin
                        for (int dx = -ri; dx <= ri; dx++)
                        begin
                            if (dx * dx + dy * dy <= ri * ri)
                            begin
                                plot(xi + dx, yi + dy, c);
                            end
                        end
                    end
                end
                MODE_READ:
                begin
                    if (xi >= 0 && xi < SCREEN_WIDTH && yi >= 0 && yi < SCREEN_HEIGHT)
                    begin
                        value = pixels[yi * SCREEN_WIDTH + xi];
                    end
                end
                default: ;
            endcase
            expected_colors.push_back(value);
        endfunction

        function void check_result(logic [15:0] got);
            logic [15:0] want;
            if (expected_colors.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("result beat with no command outstanding: read_color %h", got);
                end
            end
            else
            begin
                want = expected_colors.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("read_color mismatch: expected %h, got %h", want, got);
                    end
                end
            end
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction

        function int failures();
            return errors + expected_colors.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         mode;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic [9:0]         width;
    logic [9:0]         height;
    logic [8:0]         radius;
    logic [15:0]        fill_color;
    logic               done;
    logic [15:0]        read_color;

    frame_model model;
    bit steady;
    int idle_cycles;

    shape_fill_engine u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .width      (width),
        .height     (height),
        .radius     (radius),
        .fill_color (fill_color),
        .done       (done),
        .read_color (read_color)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                model.check_result(read_color);
            end
            if (start && !busy)
            begin
                model.note_command(mode, pos_x, pos_y, width, height, radius, fill_color);
            end
            if (done || (start && !busy))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_command(input logic [2:0] m, input int x, input int y,
                                input int w, input int h, input int r,
                                input logic [15:0] c);
        int gap;
        int pick;
        start      <= 1'b1;
        mode       <= m;
        pos_x      <= x[10:0];
        pos_y      <= y[10:0];
        width      <= w[9:0];
        height     <= h[9:0];
        radius     <= r[8:0];
        fill_color <= c;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pick = $urandom_range(0, 99);
        if (steady || pick < 50)
        begin
            gap = 0;
        end
        else if (pick < 85)
        begin
            gap = $urandom_range(1, 3);
        end
        else if (pick < 97)
        begin
            gap = $urandom_range(4, 10);
        end
        else
        begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (model.pending() != 0);
        @(posedge clk);
    endtask

    initial
    begin
        int kind;
        int x, y, w, h, r;
        int last_x, last_y, last_w, last_h;
        int big_left, clears_left;
        logic [2:0] m;

        model = new();
        idle_cycles = 0;
        steady = 1'b0;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        mode       <= MODE_CLEAR;
        pos_x      <= '0;
        pos_y      <= '0;
        width      <= '0;
        height     <= '0;
        radius     <= '0;
        fill_color <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The frame contents are undefined after reset, so a clear goes first.
        send_command(MODE_CLEAR, 0, 0, 0, 0, 0, 16'hFFFF);
        send_command(MODE_READ, 0, 0, 0, 0, 0, 16'h0000);
        send_command(MODE_READ, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0, 0, 16'h0000);
        send_command(MODE_RECT, -5, -5, 20, 10, 0, 16'hFFFF);
        send_command(MODE_READ, 0, 0, 0, 0, 0, 16'h0000);
        send_command(MODE_READ, 14, 4, 0, 0, 0, 16'h0000);
        send_command(MODE_READ, 15, 4, 0, 0, 0, 16'h0000);
        steady = 1'b1;
        send_command(MODE_RECT, 10, 10, 0, 5, 0, 16'h1234);
        send_command(MODE_RECT, 10, 10, 5, 0, 0, 16'h1234);
        send_command(MODE_RECT, -1024, -1024, 1023, 1023, 511, 16'h5555);
        send_command(MODE_RECT, SCREEN_WIDTH - 10, SCREEN_HEIGHT - 10, 30, 30, 0, 16'hAAAA);
        send_command(MODE_READ, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0, 0, 16'h0000);
        steady = 1'b0;
        send_command(MODE_ROUND, 40, 40, 30, 20, 8, 16'hF800);
        send_command(MODE_READ, 40, 40, 0, 0, 0, 16'h0000);
        send_command(MODE_READ, 69, 59, 0, 0, 0, 16'h0000);
        send_command(MODE_ROUND, 100, 20, 10, 10, 20, 16'h07E0);
        send_command(MODE_ROUND, 200, 10, 9, 5, 0, 16'h001F);
        send_command(MODE_CIRCLE, 0, 0, 0, 0, 10, 16'h8001);
        send_command(MODE_READ, 7, 7, 0, 0, 0, 16'h0000);
        send_command(MODE_CIRCLE, -1024, -1024, 0, 0, 511, 16'h3333);
        send_command(MODE_CIRCLE, 160, 120, 0, 0, 511, 16'h7BEF);
        send_command(MODE_CIRCLE, 150, 90, 0, 0, 0, 16'h0000);
        send_command(MODE_READ, -1, SCREEN_HEIGHT - 1, 0, 0, 0, 16'h0000);
        send_command(MODE_READ, SCREEN_WIDTH, 0, 0, 0, 0, 16'h0000);
        send_command(MODE_READ, 1023, -1024, 0, 0, 0, 16'h0000);
        send_command(MODE_SPARE_FIRST, 5, 5, 50, 50, 5, 16'hFFFF);
        send_command(MODE_SPARE_LAST, 6, 6, 50, 50, 5, 16'hFFFF);

        last_x = 150;
        last_y = 90;
        last_w = 1;
        last_h = 1;
        big_left = 4;
        clears_left = 1;
        for (int i = 0; i < 115; i++)
        begin
            if (i % 25 == 0)
            begin
                steady = ($urandom_range(0, 2) == 0);
            end
            if (i == 70)
            begin
                drain_results();
            end
            kind = $urandom_range(0, 99);
            if (kind < 2 && clears_left > 0)
            begin
                clears_left--;
                send_command(MODE_CLEAR, 0, 0, 0, 0, 0, 16'($urandom));
            end
            else if (kind < 40 || kind >= 96)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    x = last_x - 2 + $urandom_range(0, last_w + 3);
                    y = last_y - 2 + $urandom_range(0, last_h + 3);
                end
                else
                begin
                    x = $urandom_range(0, SCREEN_WIDTH + 7) - 4;
                    y = $urandom_range(0, SCREEN_HEIGHT + 7) - 4;
                end
                x = (x > 1023) ? 1023 : ((x < -1024) ? -1024 : x);
                y = (y > 1023) ? 1023 : ((y < -1024) ? -1024 : y);
                send_command(MODE_READ, x, y, $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom_range(0, 511),
                             16'($urandom));
            end
            else if (kind >= 92)
            begin
                m = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
                send_command(m, $urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
                             $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 511), 16'($urandom));
            end
            else
            begin
                m = (kind < 55) ? MODE_RECT : ((kind < 75) ? MODE_ROUND : MODE_CIRCLE);
                if (big_left > 0 && $urandom_range(0, 19) == 0)
                begin
                    big_left--;
                    x = $urandom_range(0, 2047) - 1024;
                    y = $urandom_range(0, 2047) - 1024;
                    w = $urandom_range(0, 1023);
                    h = $urandom_range(0, 1023);
                    r = $urandom_range(0, 511);
                end
                else
                begin
                    x = $urandom_range(0, SCREEN_WIDTH + 59) - 30;
                    y = $urandom_range(0, SCREEN_HEIGHT + 59) - 30;
                    w = $urandom_range(0, 64);
                    h = $urandom_range(0, 64);
                    if (m == MODE_CIRCLE)
                    begin
                        r = $urandom_range(0, 36);
                    end
                    else
                    begin
                        r = $urandom_range(0, ((w < h) ? w : h) / 2 + 3);
                    end
                end
                send_command(m, x, y, w, h, r, 16'($urandom));
                if (m == MODE_CIRCLE)
                begin
                    last_x = x - r;
                    last_y = y - r;
                    last_w = 2 * r + 1;
                    last_h = 2 * r + 1;
                end
                else
                begin
                    last_x = x;
                    last_y = y;
                    last_w = w;
                    last_h = h;
                end
            end
        end

        drain_results();
        repeat (16) @(posedge clk);
        if (model.failures() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> shape_fill_engine.f
rtl/sfe_pkg.sv
rtl/sfe_ram.sv
rtl/shape_fill_engine.sv
tb/testbench.sv
